// File: sv/sldf_pkg.sv
package sldf_pkg;

  // frame parse phase
  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_LENLO   = 3'd2,
    PH_LENHI   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRCLO   = 3'd5,
    PH_CRCHI   = 3'd6
  } phase_e;

  // result event codes
  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_CRCERR  = 3'd2,
    EV_SYNCERR = 3'd3,
    EV_LENERR  = 3'd4
  } event_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_idx_e;

  localparam logic [7:0]  SyncFirstRst  = 8'hB5;
  localparam logic [7:0]  SyncSecondRst = 8'h00;
  localparam logic [15:0] MaxLenRst     = 16'd4096;

  // input word
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } in_t;

  // result word
  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic [15:0] crc_value;
  } out_t;

  // configuration registers as seen by the parser
  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_len;
  } cfg_t;

endpackage

// File: sv/sldf_if.sv
interface sldf_in_if;
  logic           valid;
  logic           ready;
  sldf_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sldf_out_if;
  logic           valid;
  logic           ready;
  sldf_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/sync_length_crc16_deframer.sv
// path: a byte is taken into an input register, parsed from there by the core and its
// result word, if any, is written into the output register and shown from it
// throughput: one byte per cycle, limited only by the output consumer's ready
// reset (rst_ni low, asynchronous): parser waits for a first sync byte, crc at ffff,
// registers at sync b5/00 and max length 4096, both stages empty
module sync_length_crc16_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  sldf_in_if.sink     rx_i,
  sldf_out_if.source  ev_o
);
  import sldf_pkg::*;

  cfg_t cfg_q;
  logic in_valid_q;
  in_t  in_q;
  logic out_valid_q;
  out_t out_q;

  logic out_free;
  logic step;
  logic res_valid;
  out_t res;

  // a parsed word moves on when the output slot is free or being drained
  assign out_free   = !out_valid_q || ev_o.ready;
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || step;

  assign ev_o.valid = out_valid_q;
  assign ev_o.data  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sync_first: SyncFirstRst, sync_second: SyncSecondRst,
                 max_payload_len: MaxLenRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  cfg_q.sync_first      <= cfg_wdata_i[7:0];
        CFG_SYNC_SECOND: cfg_q.sync_second     <= cfg_wdata_i[7:0];
        CFG_MAX_LEN:     cfg_q.max_payload_len <= cfg_wdata_i;
        default:         cfg_q                 <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_q <= rx_i.data;
  end

  sldf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) out_q <= res;
  end

endmodule

// File: sv/sldf_core.sv
module sldf_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  sldf_pkg::in_t  item_i,
  input  sldf_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  output sldf_pkg::out_t res_o
);
  import sldf_pkg::*;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // crc-16/ccitt-false update over one byte, msb first
  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CrcPoly;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic        sync_match_q, sync_match_d;
  logic [7:0]  length_low_q, length_low_d;
  logic [15:0] payload_len_q, payload_len_d;
  logic [15:0] payload_left_q, payload_left_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_low_q, crc_low_d;
  logic        dropping_q, dropping_d;

  logic [7:0]  b;
  logic        last;
  logic [15:0] crc_next;
  logic [15:0] len_rx;
  logic [15:0] left_dec;
  logic        hdr_err;

  assign b        = item_i.rx_byte;
  assign last     = item_i.chunk_end;
  assign crc_next = crc_upd(crc_q, b);
  assign len_rx   = {b, length_low_q};
  assign left_dec = payload_left_q - 16'd1;
  assign hdr_err  = !sync_match_q || (len_rx > cfg_i.max_payload_len);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (!dropping_q) begin
      case (phase_q)
        PH_SYNC1:   phase_d = PH_LENLO;
        PH_LENLO:   phase_d = PH_LENHI;
        PH_LENHI: begin
          if (hdr_err)             phase_d = PH_SYNC0;
          else if (len_rx == '0)   phase_d = PH_CRCLO;
          else                     phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: if (left_dec == '0) phase_d = PH_CRCLO;
        PH_CRCLO:   phase_d = PH_CRCHI;
        PH_CRCHI:   phase_d = PH_SYNC0;
        default:    phase_d = PH_SYNC1;
      endcase
    end
  end

  // datapath state
  always_comb begin
    sync_match_d   = sync_match_q;
    length_low_d   = length_low_q;
    payload_len_d  = payload_len_q;
    payload_left_d = payload_left_q;
    crc_d          = crc_q;
    crc_low_d      = crc_low_q;
    dropping_d     = dropping_q;
    if (dropping_q) begin
      if (last) dropping_d = 1'b0;
    end else begin
      case (phase_q)
        PH_SYNC1: sync_match_d = sync_match_q && (b == cfg_i.sync_second);
        PH_LENLO: begin
          length_low_d = b;
          crc_d        = crc_next;
        end
        PH_LENHI: begin
          payload_len_d = len_rx;
          crc_d         = crc_next;
          if (hdr_err) dropping_d     = !last;
          else         payload_left_d = len_rx;
        end
        PH_PAYLOAD: begin
          crc_d          = crc_next;
          payload_left_d = left_dec;
        end
        PH_CRCLO: crc_low_d = b;
        PH_CRCHI: ;
        default: begin
          sync_match_d = (b == cfg_i.sync_first);
          crc_d        = CrcInit;
        end
      endcase
    end
  end

  // result word
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '{event_res: EV_DATA, data_byte: 8'h00,
                    frame_length: payload_len_q, crc_value: 16'h0000};
    if (!dropping_q) begin
      case (phase_q)
        PH_LENHI: begin
          res_valid_o        = hdr_err;
          res_o.event_res    = sync_match_q ? EV_LENERR : EV_SYNCERR;
          res_o.frame_length = len_rx;
        end
        PH_PAYLOAD: begin
          res_valid_o     = 1'b1;
          res_o.data_byte = b;
        end
        PH_CRCHI: begin
          res_valid_o     = 1'b1;
          res_o.event_res = ({b, crc_low_q} == crc_q) ? EV_GOOD : EV_CRCERR;
          res_o.crc_value = crc_q;
        end
        default: res_valid_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_SYNC0;
      sync_match_q   <= 1'b1;
      length_low_q   <= '0;
      payload_len_q  <= '0;
      payload_left_q <= '0;
      crc_q          <= CrcInit;
      crc_low_q      <= '0;
      dropping_q     <= 1'b0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      sync_match_q   <= sync_match_d;
      length_low_q   <= length_low_d;
      payload_len_q  <= payload_len_d;
      payload_left_q <= payload_left_d;
      crc_q          <= crc_d;
      crc_low_q      <= crc_low_d;
      dropping_q     <= dropping_d;
    end
  end

endmodule

// File: bench/sync_length_crc16_deframer_test.sv
module sync_length_crc16_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sldf_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 240;

  // stimulus frame shapes
  typedef enum int {
    FR_GOOD,
    FR_BADCRC,
    FR_BADSYNC,
    FR_BIGLEN
  } frame_kind_e;

  // deframer predictor and result checker
  class frame_checker;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [15:0] len_cap;
    phase_e      ph;
    bit          sync_ok;
    logic [7:0]  len_lo;
    logic [7:0]  crc_lo;
    logic [15:0] plen;
    logic [15:0] left;
    logic [15:0] crc;
    bit          dropping;
    out_t        want_q[$];
    int          errors;
    int          bytes_in;
    int          words_out;
    int          seen[5];

    function new();
      sync_a   = SyncFirstRst;
      sync_b   = SyncSecondRst;
      len_cap  = MaxLenRst;
      ph       = PH_SYNC0;
      sync_ok  = 1'b1;
      len_lo   = '0;
      crc_lo   = '0;
      plen     = '0;
      left     = '0;
      crc      = 16'hFFFF;
      dropping = 1'b0;
    endfunction

    // crc-16/ccitt-false, msb first, one byte
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      end
      return r;
    endfunction

    function void set_cfg(logic [7:0] s1, logic [7:0] s2, logic [15:0] mx);
      sync_a  = s1;
      sync_b  = s2;
      len_cap = mx;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function void push_result(event_e ev, logic [7:0] d, logic [15:0] ln, logic [15:0] c);
      out_t w;
      w.event_res    = ev;
      w.data_byte    = d;
      w.frame_length = ln;
      w.crc_value    = c;
      want_q.insert(want_q.size(), w);
    endfunction

    // advance the parser by one accepted word
    function void take_byte(in_t w);
      logic [7:0] b;
      b = w.rx_byte;
      bytes_in++;
      if (dropping) begin
        if (w.chunk_end) dropping = 1'b0;
        return;
      end
      case (ph)
        PH_SYNC1: begin
          sync_ok = sync_ok && (b == sync_b);
          ph = PH_LENLO;
        end
        PH_LENLO: begin
          len_lo = b;
          crc = crc_next(crc, b);
          ph = PH_LENHI;
        end
        PH_LENHI: begin
          plen = {b, len_lo};
          crc = crc_next(crc, b);
          if (!sync_ok || plen > len_cap) begin
            // sync mismatch wins over length too large
            push_result(sync_ok ? EV_LENERR : EV_SYNCERR, 8'h00, plen, 16'h0000);
            ph = PH_SYNC0;
            dropping = !w.chunk_end;
          end else begin
            left = plen;
            ph = (plen == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc = crc_next(crc, b);
          left = left - 16'd1;
          if (left == 16'd0) ph = PH_CRCLO;
          push_result(EV_DATA, b, plen, 16'h0000);
        end
        PH_CRCLO: begin
          crc_lo = b;
          ph = PH_CRCHI;
        end
        PH_CRCHI: begin
          push_result(({b, crc_lo} == crc) ? EV_GOOD : EV_CRCERR, 8'h00, plen, crc);
          ph = PH_SYNC0;
        end
        default: begin
          sync_ok = (b == sync_a);
          crc = 16'hFFFF;
          ph = PH_SYNC1;
        end
      endcase
    endfunction

    // compare one result word against the oldest prediction
    function void check_word(out_t got);
      out_t want;
      words_out++;
      if (want_q.size() == 0) begin
        $error("result word with none pending: event %0d data %02h length %0d crc %04h",
               got.event_res, got.data_byte, got.frame_length, got.crc_value);
        errors++;
        return;
      end
      want = want_q.pop_front();
      seen[int'(want.event_res)]++;
      if (got.event_res !== want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.crc_value !== want.crc_value) begin
        $error("crc_value: expected %04h, got %04h", want.crc_value, got.crc_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  sldf_in_if  rx_if ();
  sldf_out_if ev_if ();

  frame_checker sb;
  in_t          stim_q[$];
  logic [7:0]   cur_s1;
  logic [7:0]   cur_s2;
  logic [15:0]  cur_max;
  int           cycles;

  sync_length_crc16_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .ev_o        (ev_if)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // word monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (rx_if.valid === 1'b1 && rx_if.ready === 1'b1) sb.take_byte(rx_if.data);
      if (ev_if.valid === 1'b1 && ev_if.ready === 1'b1) sb.check_word(ev_if.data);
    end
  end

  // result consumer, with a stall pattern that is picked anew at random
  initial begin
    int mode;
    int span;
    int k;
    mode = 0;
    span = 0;
    k = 0;
    ev_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(50, 300);
      end
      span--;
      k++;
      case (mode)
        0: ev_if.ready <= 1'b1;
        1: ev_if.ready <= 1'($urandom_range(0, 1));
        2: ev_if.ready <= ((k % 8) >= 3);
        default: ev_if.ready <= ((k % 16) >= 12);
      endcase
    end
  end

  function automatic void push_word(logic [7:0] b, bit ce);
    in_t w;
    w.rx_byte   = b;
    w.chunk_end = ce;
    stim_q.insert(stim_q.size(), w);
  endfunction

  // chunk ends now and then inside a frame, which must not matter
  function automatic bit rand_ce();
    return ($urandom_range(0, 19) == 0);
  endfunction

  // hdr_end: 1 chunk ends on the failing header word, 0 junk follows, -1 random
  function automatic void add_frame(frame_kind_e kind, int len, int fill, int hdr_end);
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  b;
    logic [7:0]  flip;
    logic [15:0] ln;
    logic [15:0] crc;
    bit          ce;
    int          n;
    s1 = cur_s1;
    s2 = cur_s2;
    ln = 16'(len);
    if (kind == FR_BADSYNC) begin
      flip = 8'($urandom_range(1, 255));
      case ($urandom_range(0, 2))
        0: s1 ^= flip;
        1: s2 ^= flip;
        default: begin
          s1 ^= flip;
          s2 ^= 8'($urandom_range(1, 255));
        end
      endcase
    end
    push_word(s1, rand_ce());
    push_word(s2, rand_ce());
    crc = frame_checker::crc_next(16'hFFFF, ln[7:0]);
    push_word(ln[7:0], rand_ce());
    if (kind == FR_BADSYNC || kind == FR_BIGLEN) begin
      ce = (hdr_end < 0) ? ($urandom_range(0, 2) == 0) : (hdr_end != 0);
      push_word(ln[15:8], ce);
      if (!ce) begin
        // junk up to the chunk end, all of it dropped
        n = $urandom_range(0, 4);
        repeat (n) push_word(8'($urandom), 1'b0);
        push_word(8'($urandom), 1'b1);
      end
      return;
    end
    crc = frame_checker::crc_next(crc, ln[15:8]);
    push_word(ln[15:8], rand_ce());
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      crc = frame_checker::crc_next(crc, b);
      push_word(b, rand_ce());
    end
    if (kind == FR_BADCRC) crc ^= 16'($urandom_range(1, 65535));
    push_word(crc[7:0], rand_ce());
    push_word(crc[15:8], 1'($urandom_range(0, 1)));
  endfunction

  // mostly short payloads, now and then the limit itself, capped at 200
  function automatic int pick_len();
    int cap;
    int r;
    cap = int'(cur_max);
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, (cap < 8) ? cap : 8);
    if (r < 19) return $urandom_range(0, (cap < 40) ? cap : 40);
    return (cap < 200) ? cap : 200;
  endfunction

  function automatic void add_random_frame();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      add_frame(FR_GOOD, pick_len(), -1, -1);
    end else if (r < 72) begin
      add_frame(FR_BADCRC, pick_len(), -1, -1);
    end else if (r < 82 || (r < 92 && cur_max == 16'hFFFF)) begin
      add_frame(FR_BADSYNC, $urandom_range(0, 65535), -1, -1);
    end else if (r < 92) begin
      add_frame(FR_BIGLEN, $urandom_range(0, 1) ? int'(cur_max) + 1
                : $urandom_range(int'(cur_max) + 1, 65535), -1, -1);
    end else begin
      // line noise that knocks the parser out of step
      n = $urandom_range(1, 6);
      repeat (n) push_word(8'($urandom), ($urandom_range(0, 3) == 0));
    end
  endfunction

  // write all three registers while the parser is idle
  task automatic set_regs(logic [7:0] s1, logic [7:0] s2, logic [15:0] mx);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_FIRST;
    cfg_wdata_i <= {8'h00, s1};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SYNC_SECOND;
    cfg_wdata_i <= {8'h00, s2};
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MAX_LEN;
    cfg_wdata_i <= mx;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_cfg(s1, s2, mx);
    cur_s1  = s1;
    cur_s2  = s2;
    cur_max = mx;
  endtask

  // send the queued words in bursts with random gaps
  task automatic send_stream();
    int burst;
    int gap;
    burst = 0;
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          @(negedge clk_i);
          rx_if.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      rx_if.valid <= 1'b1;
      rx_if.data  <= stim_q.pop_front();
      do @(posedge clk_i); while (rx_if.ready !== 1'b1);
      burst--;
    end
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
  endtask

  // wait out pending results, then the pipeline depth for silent words
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SYNC_FIRST;
    cfg_wdata_i = '0;
    rx_if.valid = 1'b0;
    rx_if.data  = '0;
    cur_s1  = SyncFirstRst;
    cur_s2  = SyncSecondRst;
    cur_max = MaxLenRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty frame, all-ones payload, sync error beating a huge length
    // with the chunk ending on that word, length error with dropping, bad crc
    add_frame(FR_GOOD, 0, -1, 0);
    add_frame(FR_GOOD, 1, 255, 0);
    add_frame(FR_BADSYNC, 65535, -1, 1);
    add_frame(FR_BIGLEN, int'(MaxLenRst) + 1, -1, 0);
    add_frame(FR_BADCRC, 0, -1, 0);
    send_stream();
    drain();

    // random frames under several register settings, extremes included
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_regs(8'h00, 8'h00, 16'h0000);
        1: set_regs(8'hFF, 8'hFF, 16'hFFFF);
        2: set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 16)));
        3: set_regs(8'($urandom), 8'($urandom), 16'($urandom));
        default: set_regs(SyncFirstRst, SyncSecondRst, MaxLenRst);
      endcase
      while (stim_q.size() < PhaseWords) add_random_frame();
      send_stream();
      drain();
    end

    $display("covered %0d input words and %0d result words over six register settings",
             sb.bytes_in, sb.words_out);
    $display("events: %0d data, %0d good, %0d crc mismatch, %0d sync mismatch, %0d too long",
             sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4]);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
